// ===== src/kvt_pkg.sv =====
// Package for the key/value table: sizes, command and status codes,
// entry and memory request types. No dependencies.
`default_nettype none

package kvt_pkg;

  localparam int ENTRIES = 16;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAST,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== src/key_value_table_unit.sv =====
// Top level of the key/value table: sequencer plus entry RAM.
// Depends on kvt_pkg, kvt_ctrl and kvt_ram.
//
// Usage:
//   A request (in_command, in_key, in_value) is taken at a rising edge where
//   start is high and busy is low. Commands: put, get, remove; code 3 is a
//   no-op that returns ok.
//   Exactly one result per request appears on out_status, out_read_value and
//   out_entry_count for one cycle, flagged by out_valid. The receiver cannot
//   stall; the result is simply presented for that single cycle.
//   A put or get scans the entries up to and including a hit, or all of them
//   on a miss; a remove first reads the tail entry. An empty table or the
//   no-op code skips the scan. The scan reads one entry per cycle through
//   the single RAM read port, then the done state writes back at most once
//   and presents the result. busy drops in the cycle out_valid is high, so
//   a new request may be taken then.
//   Reset (rst_n low, synchronous) empties the table and clears the
//   sequencer; RAM contents are not cleared, only the count is.
`default_nettype none

module key_value_table_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_command,
  input  wire logic signed [kvt_pkg::KEY_W-1:0] in_key,
  input  wire logic signed [kvt_pkg::VAL_W-1:0] in_value,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic signed [kvt_pkg::VAL_W-1:0]     out_read_value,
  output logic [kvt_pkg::OUT_CNT_W-1:0]        out_entry_count
);
  import kvt_pkg::*;

  mem_req_t           mem_req;
  entry_t             mem_rdata;
  logic [ENTRY_W-1:0] rdata_raw;
  logic [VAL_W-1:0]   read_value;

  assign mem_rdata      = entry_t'(rdata_raw);
  assign out_read_value = read_value;

  kvt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_value        (in_value),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (read_value),
    .out_entry_count (out_entry_count)
  );

  kvt_ram #(
    .DW    (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata_raw)
  );

endmodule

`default_nettype wire

// ===== src/kvt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module kvt_ram #(
  parameter int DW    = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/kvt_ctrl.sv =====
// Command sequencer for the key/value table: linear scan over the entry RAM,
// then at most one write-back and the result. Uses kvt_pkg.
`default_nettype none

module kvt_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      in_command,
  input  wire logic [kvt_pkg::KEY_W-1:0]       in_key,
  input  wire logic [kvt_pkg::VAL_W-1:0]       in_value,
  output kvt_pkg::mem_req_t                    mem_req,
  input  wire kvt_pkg::entry_t                 mem_rdata,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [kvt_pkg::VAL_W-1:0]            out_read_value,
  output logic [kvt_pkg::OUT_CNT_W-1:0]        out_entry_count
);
  import kvt_pkg::*;

  state_t             state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   value_r, value_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic [ADDR_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               last_pend_r, last_pend_nxt;
  logic               found_r, found_nxt;
  logic [ADDR_W-1:0]  slot_r, slot_nxt;
  logic [VAL_W-1:0]   fval_r, fval_nxt;
  entry_t             last_r, last_nxt;
  logic               ov_r, ov_nxt;
  logic [1:0]         ost_r, ost_nxt;
  logic [VAL_W-1:0]   orv_r, orv_nxt;
  logic [CNT_W-1:0]   cnt_m1;
  logic               hit;

  assign cnt_m1 = count_r - 1'b1;
  assign hit    = pend_r && (mem_rdata.key == key_r);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = pend_r;
    last_pend_nxt = last_pend_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    fval_nxt      = fval_r;
    last_nxt      = last_r;
    ov_nxt        = 1'b0;
    ost_nxt       = ost_r;
    orv_nxt       = orv_r;
    mem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt       = in_command;
          key_nxt       = in_key;
          value_nxt     = in_value;
          issue_nxt     = '0;
          pend_nxt      = 1'b0;
          last_pend_nxt = 1'b0;
          found_nxt     = 1'b0;
          if (count_r == '0 || in_command == CMD_NOP) begin
            state_nxt = S_DONE;
          end else if (in_command == CMD_REMOVE) begin
            state_nxt = S_LAST;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_LAST: begin
        // fetch the tail entry, it fills the hole on a remove
        mem_req.re    = 1'b1;
        mem_req.raddr = cnt_m1[ADDR_W-1:0];
        last_pend_nxt = 1'b1;
        state_nxt     = S_SCAN;
      end

      S_SCAN: begin
        if (last_pend_r) begin
          last_nxt      = mem_rdata;
          last_pend_nxt = 1'b0;
        end
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = cmp_idx_r;
          fval_nxt  = mem_rdata.value;
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (issue_r < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = issue_r[ADDR_W-1:0];
          cmp_idx_nxt   = issue_r[ADDR_W-1:0];
          issue_nxt     = CNT_W'(issue_r + 1'b1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        ov_nxt    = 1'b1;
        ost_nxt   = STAT_OK;
        orv_nxt   = '0;
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_PUT: begin
            if (found_r) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = slot_r;
              mem_req.wdata = '{key: key_r, value: value_r};
            end else if (count_r == CNT_W'(ENTRIES)) begin
              ost_nxt = STAT_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count_r[ADDR_W-1:0];
              mem_req.wdata = '{key: key_r, value: value_r};
              count_nxt     = CNT_W'(count_r + 1'b1);
            end
          end
          CMD_GET: begin
            if (found_r) begin
              orv_nxt = fval_r;
            end else begin
              ost_nxt = STAT_NOT_FOUND;
              orv_nxt = '1;
            end
          end
          CMD_REMOVE: begin
            if (found_r) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = slot_r;
              mem_req.wdata = last_r;
              count_nxt     = cnt_m1;
            end else begin
              ost_nxt = STAT_NOT_FOUND;
            end
          end
          default: begin
            ost_nxt = STAT_OK;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      last_pend_r <= 1'b0;
      found_r     <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      last_pend_r <= last_pend_nxt;
      found_r     <= found_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    value_r   <= value_nxt;
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    fval_r    <= fval_nxt;
    last_r    <= last_nxt;
    ost_r     <= ost_nxt;
    orv_r     <= orv_nxt;
  end

  // count register already holds the post-command value when the strobe shows
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_read_value  = orv_r;
  assign out_entry_count = OUT_CNT_W'(count_r);

endmodule

`default_nettype wire

// ===== tb/sv/key_value_table_checker.sv =====
// Checker for key_value_table_unit: watches the request and result channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on kvt_pkg.
module key_value_table_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [1:0]                       in_command,
  input  logic [kvt_pkg::KEY_W-1:0]        in_key,
  input  logic [kvt_pkg::VAL_W-1:0]        in_value,
  input  logic                             out_valid,
  input  logic [1:0]                       out_status,
  input  logic [kvt_pkg::VAL_W-1:0]        out_read_value,
  input  logic [kvt_pkg::OUT_CNT_W-1:0]    out_entry_count,
  output int                               mismatches,
  output int                               awaiting
);
  import kvt_pkg::*;

  typedef struct packed {
    logic [1:0]           status;
    logic [VAL_W-1:0]     read_value;
    logic [OUT_CNT_W-1:0] entry_count;
  } response_t;

  logic [KEY_W-1:0] table_keys   [ENTRIES];
  logic [VAL_W-1:0] table_values [ENTRIES];
  logic [31:0]      table_used;

  response_t expected_responses[$];
  response_t oldest;

  initial begin
    mismatches = 0;
    awaiting   = 0;
    table_used = '0;
  end

  // Linear search over the occupied slots; -1 on a miss.
  function automatic int find_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < table_used; i++) begin
      if (table_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic response_t apply_command(input logic [1:0] cmd,
                                              input logic [KEY_W-1:0] key,
                                              input logic [VAL_W-1:0] value);
    response_t resp;
    int        slot;
    int        last;
    resp.status     = STAT_OK;
    resp.read_value = '0;
    slot = find_slot(key);
    case (cmd)
      CMD_PUT: begin
        if (slot >= 0) begin
          table_values[slot] = value;
        end else if (table_used >= ENTRIES) begin
          resp.status = STAT_FULL;
        end else begin
          table_keys[table_used]   = key;
          table_values[table_used] = value;
          table_used = table_used + 1;
        end
      end
      CMD_GET: begin
        if (slot >= 0) begin
          resp.read_value = table_values[slot];
        end else begin
          resp.status     = STAT_NOT_FOUND;
          resp.read_value = '1;
        end
      end
      CMD_REMOVE: begin
        if (slot >= 0) begin
          // tail entry fills the hole
          last = table_used - 1;
          table_keys[slot]   = table_keys[last];
          table_values[slot] = table_values[last];
          table_used = table_used - 1;
        end else begin
          resp.status = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
    resp.entry_count = table_used[OUT_CNT_W-1:0];
    return resp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      table_used = '0;
      expected_responses.delete();
      awaiting = 0;
    end else begin
      // result check first: a new request may be taken at the same edge
      if (out_valid) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected result status %0d read_value %h entry_count %0d",
                   $time, out_status, out_read_value, out_entry_count);
          mismatches++;
        end else begin
          oldest = expected_responses.pop_front();
          if (out_status !== oldest.status) begin
            $display("%0t: status expected %0d, got %0d", $time, oldest.status, out_status);
            mismatches++;
          end
          if (out_read_value !== oldest.read_value) begin
            $display("%0t: read_value expected %h, got %h", $time, oldest.read_value,
                     out_read_value);
            mismatches++;
          end
          if (out_entry_count !== oldest.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d", $time, oldest.entry_count,
                     out_entry_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_responses.push_back(apply_command(in_command, in_key, in_value));
      end
      awaiting = expected_responses.size();
    end
  end

endmodule

// ===== tb/sv/key_value_table_unit_test.sv =====
// Testbench top for key_value_table_unit: clock, reset, directed and random requests,
// verdict. Depends on kvt_pkg, key_value_table_unit and key_value_table_checker.
module key_value_table_unit_test;
  import kvt_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_command;
  logic [KEY_W-1:0]  in_key;
  logic [VAL_W-1:0]  in_value;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [VAL_W-1:0]  out_read_value;
  logic [OUT_CNT_W-1:0] out_entry_count;

  int                mismatches;
  int                awaiting;
  int                idle_pct;
  logic [KEY_W-1:0]  key_pool [32];

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  key_value_table_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

  key_value_table_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .mismatches      (mismatches),
    .awaiting        (awaiting)
  );

  // Offers the request each cycle with probability set by idle_pct; returns at the
  // edge where it is taken, leaving start high so a following request can chain.
  task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    logic offer;
    in_command <= cmd;
    in_key     <= key;
    in_value   <= value;
    forever begin
      offer = ($urandom_range(99) >= idle_pct);
      start <= offer;
      @(posedge clk);
      if (offer && !busy) break;
    end
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  // Bursts with a varying working set and put weight, so the table swings
  // between empty and full.
  task automatic run_random(input int n);
    int          burst_left;
    int          active;
    int          put_pct;
    int          roll;
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    burst_left = 0;
    active     = 2;
    put_pct    = 50;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(80, 20);
        active     = $urandom_range(32, 2);
        put_pct    = $urandom_range(75, 15);
        repeat (3) key_pool[$urandom_range(31)] = $urandom;
      end
      burst_left--;
      if ($urandom_range(99) < put_pct) begin
        cmd = CMD_PUT;
      end else begin
        roll = $urandom_range(99);
        cmd  = (roll < 55) ? CMD_GET : (roll < 95) ? CMD_REMOVE : CMD_NOP;
      end
      key  = key_pool[$urandom_range(active - 1)];
      roll = $urandom_range(99);
      if (roll < 5) key = $urandom;
      else if (roll < 10) key = key ^ (32'h1 << $urandom_range(31));  // near miss
      value = ($urandom_range(9) == 0) ? pick_extreme() : $urandom;
      send_request(cmd, key, value);
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_command <= CMD_PUT;
    in_key     <= '0;
    in_value   <= '0;
    idle_pct   = 26;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: misses and the no-op code
    send_request(CMD_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(CMD_REMOVE, 32'h0000_0000, 32'h0);
    send_request(CMD_NOP, 32'hffff_ffff, 32'hffff_ffff);
    // extreme keys and values
    send_request(CMD_PUT, 32'h0000_0000, 32'h7fff_ffff);
    send_request(CMD_PUT, 32'hffff_ffff, 32'h8000_0000);
    send_request(CMD_PUT, 32'h8000_0000, 32'hffff_ffff);
    send_request(CMD_PUT, 32'h7fff_ffff, 32'h0000_0000);
    send_request(CMD_GET, 32'h8000_0000, 32'h0);
    send_request(CMD_PUT, 32'h0000_0000, 32'h5a5a_5a5a);   // overwrite
    send_request(CMD_REMOVE, 32'h0000_0000, 32'h0);        // tail moves into slot 0
    send_request(CMD_REMOVE, 32'h8000_0000, 32'h0);        // drop the tail itself
    send_request(CMD_REMOVE, 32'h0000_0000, 32'h0);        // absent
    send_request(CMD_GET, 32'hffff_ffff, 32'h0);
    // fill up, then a new key when full and an overwrite when full
    for (int i = 0; i < ENTRIES - 2; i++) send_request(CMD_PUT, 32'h1 << i, $urandom);
    send_request(CMD_PUT, 32'h1234_5678, 32'h0bad_cafe);
    send_request(CMD_PUT, 32'hffff_ffff, 32'h0000_0001);
    send_request(CMD_GET, 32'hffff_ffff, 32'h0);
    send_request(CMD_REMOVE, 32'h1 << (ENTRIES - 3), 32'h0);

    run_random(430);
    idle_pct = 78;
    run_random(430);
    idle_pct = 0;
    run_random(440);
    start <= 1'b0;

    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
